>>> rtl/assert_macros.svh
// Assertion helpers for the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dphd_pkg.sv
package dphd_pkg;

    localparam int PADS = 4;
    localparam int PAD_W = 2;
    localparam int HISTORY_DEPTH = 8;
    localparam int HIST_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CFG_INPUT_SPAN = 3'd0;
    localparam logic [2:0] CFG_ON_LEVEL = 3'd1;
    localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd2;
    localparam logic [2:0] CFG_MASK_TIME = 3'd3;
    localparam logic [2:0] CFG_CROSSTALK_SHIFT = 3'd4;
    localparam logic [2:0] CFG_HISTORY_LENGTH = 3'd5;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic             in_range;
        logic [11:0]      sample;
    } word_t;

    typedef struct packed {
        logic [10:0] input_span;
        logic [11:0] on_level;
        logic [7:0]  window_length;
        logic [7:0]  mask_time;
        logic [2:0]  crosstalk_shift;
        logic [3:0]  history_length;
    } cfg_t;

endpackage

>>> rtl/drum_pad_hit_detector.sv
// Piezo drum pad hit detector for four pads. The back end works on one sample word at a
// time and takes the next only once it is through with the last: a restoring divider for
// the normalization, a walk over up to seven entries of the pad's sample history (cut
// short while the velocity window is open) and a scan of the other pads' levels. A result
// word that waits on m_ready holds the back end. A two-word queue takes new samples while
// one is in work. Each input word yields one result word with the pad number, a hit flag
// and the strike level.
`include "assert_macros.svh"

module drum_pad_hit_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_pad_index,
    input  logic [11:0] s_adc_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_pad_number,
    output logic        m_hit,
    output logic [11:0] m_strike_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    dphd_pkg::cfg_t  cfg;
    dphd_pkg::word_t q_word;
    logic            q_valid, q_ready, busy;

    dphd_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    dphd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_pad_index(s_pad_index), .s_adc_sample(s_adc_sample),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    dphd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
        .q_word(q_word), .m_valid(m_valid), .m_ready(m_ready),
        .m_pad_number(m_pad_number), .m_hit(m_hit), .m_strike_level(m_strike_level),
        .busy(busy)
    );

    `ASSERT_IMPL(a_no_level_without_hit, aclk, aresetn, m_valid && !m_hit,
        m_strike_level == 12'd0, "strike level without hit")
    `ASSERT_IMPL(a_valid_means_busy, aclk, aresetn, m_valid, busy,
        "result shown while back end idle")
    `ASSERT_NEXT(a_take_only_idle, aclk, aresetn, q_valid && q_ready,
        busy, "back end not busy after taking a word")

endmodule

>>> rtl/dphd_front.sv
module dphd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_pad_index,
    input  logic [11:0]           s_adc_sample,
    output logic                  q_valid,
    input  logic                  q_ready,
    output dphd_pkg::word_t       q_word
);

    dphd_pkg::word_t mem_reg [dphd_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push, pop;
    dphd_pkg::word_t incoming;

    assign s_ready = (count_reg != 2'(dphd_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_word = mem_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    // Classify the word: pads beyond the PADS count pass straight through.
    always_comb begin
        incoming.pad = s_pad_index[dphd_pkg::PAD_W-1:0];
        incoming.in_range = ({30'd0, s_pad_index} < dphd_pkg::PADS);
        incoming.sample = s_adc_sample;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

>>> rtl/dphd_back.sv
module dphd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dphd_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  dphd_pkg::word_t       q_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_pad_number,
    output logic                  m_hit,
    output logic [11:0]           m_strike_level,
    output logic                  busy
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FILT   = 4'd1;
    localparam logic [3:0] ST_CLAMP  = 4'd2;
    localparam logic [3:0] ST_NMUL   = 4'd3;
    localparam logic [3:0] ST_NDIV   = 4'd4;
    localparam logic [3:0] ST_HIST   = 4'd5;
    localparam logic [3:0] ST_WIN    = 4'd6;
    localparam logic [3:0] ST_OTHER  = 4'd7;
    localparam logic [3:0] ST_ENV    = 4'd8;
    localparam logic [3:0] ST_PHASE  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0]  state_reg, state_next;

    logic [7:0]  phase_reg [dphd_pkg::PADS];
    logic [9:0]  retrig_reg [dphd_pkg::PADS];
    logic [11:0] hist_reg [dphd_pkg::PADS][dphd_pkg::HISTORY_DEPTH];
    logic [12:0] wmin_reg [dphd_pkg::PADS];
    logic [12:0] wmax_reg [dphd_pkg::PADS];
    logic [11:0] ind_reg [dphd_pkg::PADS][2];
    logic signed [15:0] fd_reg [dphd_pkg::PADS][2];
    logic [10:0] envc_reg [dphd_pkg::PADS];
    logic [12:0] envmin_reg [dphd_pkg::PADS];
    logic [12:0] envmax_reg [dphd_pkg::PADS];
    logic [13:0] envth_reg [dphd_pkg::PADS];

    dphd_pkg::word_t wd_reg;
    logic [11:0] s_reg;
    logic [23:0] num_reg;
    logic [11:0] quot_reg;
    logic [12:0] rem_reg;
    logic [3:0]  div_cnt_reg;
    logic [2:0]  step_reg;
    logic [12:0] oth_reg;
    logic [12:0] p2p_reg;
    logic        mvalid_reg;
    logic [1:0]  mpad_reg;
    logic        mhit_reg;
    logic [11:0] mlvl_reg;
    logic [1:0]  scan_reg;

    logic [dphd_pkg::PAD_W-1:0] pd;
    logic [3:0]  hlen;
    logic [3:0]  hlen_m1;
    logic [dphd_pkg::HIST_W-1:0] hlast;
    logic [11:0] lo, hi;
    logic [11:0] span2;
    logic signed [13:0] diff;
    logic signed [17:0] f1;
    logic signed [19:0] fd0_x7;
    logic [16:0] fd1_mag;
    logic [18:0] fd1_x4;
    logic [34:0] fd1_prod;
    logic [16:0] fd1_q;
    logic signed [18:0] fd1_term;
    logic signed [18:0] f2;
    logic signed [15:0] f2w, f2o;
    logic [12:0] rem_sh;
    logic [12:0] scan_lvl;
    logic [12:0] xs;
    logic [12:0] canc_p2p, canc_win;
    logic [12:0] win_lvl;
    logic [12:0] nmin, nmax;
    logic [12:0] hv;
    logic [7:0]  ph;

    assign pd = wd_reg.pad;
    assign q_ready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign busy = (state_reg != ST_IDLE) || mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_pad_number = mpad_reg;
    assign m_hit = mhit_reg;
    assign m_strike_level = mlvl_reg;

    always_comb begin
        hlen = cfg.history_length;
        if (hlen == 4'd0) hlen = 4'd1;
        if (hlen > 4'(dphd_pkg::HISTORY_DEPTH)) hlen = 4'(dphd_pkg::HISTORY_DEPTH);
        hlen_m1 = hlen - 4'd1;
        hlast = hlen_m1[dphd_pkg::HIST_W-1:0];
        lo = 12'd2048 - {1'b0, cfg.input_span};
        hi = 12'd2048 + {1'b0, cfg.input_span};
        span2 = {cfg.input_span, 1'b0};
        diff = $signed({2'b00, wd_reg.sample})
            - $signed({2'b00, 12'((13'(ind_reg[pd][0]) + 13'(ind_reg[pd][1])) >> 1)});
        f1 = ($signed({{4{diff[13]}}, diff}) * 18'sd3) / 18'sd16;
        fd0_x7 = 20'(fd_reg[pd][0]) * 20'sd7;
        // The older delay term times 8/10 is 4*|x|/5 through a reciprocal multiply.
        fd1_mag = fd_reg[pd][1][15] ? 17'd0 - {fd_reg[pd][1][15], fd_reg[pd][1]}
            : {1'b0, fd_reg[pd][1]};
        fd1_x4 = {fd1_mag, 2'b00};
        fd1_prod = 35'(fd1_x4) * 35'(16'd52429);
        fd1_q = fd1_prod[34:18];
        fd1_term = fd_reg[pd][1][15] ? -$signed({2'b00, fd1_q}) : $signed({2'b00, fd1_q});
        f2 = 19'(f1) + 19'(fd0_x7 / 20'sd4) - fd1_term;
        f2w = f2[15:0];
        f2o = f2w + 16'sd2048;
        rem_sh = {rem_reg[11:0], num_reg[23]};
        ph = phase_reg[pd];
        // Level of another pad for the crosstalk scan, halved for the pair, quartered for the rest.
        scan_lvl = wmax_reg[scan_reg] - wmin_reg[scan_reg];
        scan_lvl = (scan_reg == (pd ^ 2'd1)) ? (scan_lvl >> 1) : (scan_lvl >> 2);
        xs = oth_reg >> cfg.crosstalk_shift;
        win_lvl = wmax_reg[pd] - wmin_reg[pd];
        canc_win = (win_lvl > xs) ? win_lvl - xs : 13'd0;
        canc_p2p = (oth_reg == 13'd0) ? p2p_reg : ((p2p_reg > xs) ? p2p_reg - xs : 13'd0);
        hv = {1'b0, hist_reg[pd][step_reg + 3'd1]};
        nmin = (step_reg == 3'd0) ? {1'b0, s_reg} : wmin_reg[pd];
        nmax = (step_reg == 3'd0) ? {1'b0, s_reg} : wmax_reg[pd];
        if (4'(step_reg) + 4'd1 < hlen) begin
            if (hv < nmin) nmin = hv;
            else if (hv > nmax) nmax = hv;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && q_ready) state_next = ST_FILT;
            ST_FILT: state_next = wd_reg.in_range ? ST_CLAMP : ST_OUT;
            ST_CLAMP: state_next = ST_NMUL;
            ST_NMUL: state_next = ST_NDIV;
            ST_NDIV: if (div_cnt_reg == 4'd0) state_next = ST_HIST;
            ST_HIST: state_next = ST_WIN;
            ST_WIN: if (step_reg + 3'd1 >= 3'(hlen - 4'd1) || hlen == 4'd1
                        || ph != 8'd0 && ph < cfg.window_length) state_next = ST_OTHER;
            ST_OTHER: if (scan_reg == 2'(dphd_pkg::PADS - 1)) state_next = ST_ENV;
            ST_ENV: state_next = ST_PHASE;
            ST_PHASE: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
            for (int p = 0; p < dphd_pkg::PADS; p++) begin
                phase_reg[p] <= 8'd10;
                retrig_reg[p] <= 10'd0;
                wmin_reg[p] <= 13'd0;
                wmax_reg[p] <= 13'd0;
                envc_reg[p] <= 11'd0;
                envmin_reg[p] <= 13'd0;
                envmax_reg[p] <= 13'd0;
                envth_reg[p] <= 14'd0;
                ind_reg[p][0] <= 12'd2048;
                ind_reg[p][1] <= 12'd2048;
                fd_reg[p][0] <= 16'sd0;
                fd_reg[p][1] <= 16'sd0;
                for (int h = 0; h < dphd_pkg::HISTORY_DEPTH; h++) hist_reg[p][h] <= 12'd0;
            end
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) mvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (q_valid && q_ready) wd_reg <= q_word;
                ST_FILT: if (wd_reg.in_range) begin
                    ind_reg[pd][1] <= ind_reg[pd][0];
                    ind_reg[pd][0] <= wd_reg.sample;
                    fd_reg[pd][1] <= fd_reg[pd][0];
                    fd_reg[pd][0] <= f2w;
                    s_reg <= f2o[15] ? 12'd0 : (f2o > 16'sd4095) ? 12'd4095 : f2o[11:0];
                end
                ST_CLAMP: begin
                    num_reg <= 24'(s_reg - lo) * 24'd4095;
                end
                ST_NMUL: begin
                    // Restoring division, one quotient bit per cycle. The top half of the
                    // dividend is always below the divisor, so it goes straight in.
                    rem_reg <= {1'b0, num_reg[23:12]};
                    div_cnt_reg <= 4'd11;
                    num_reg <= {num_reg[11:0], 12'd0};
                    quot_reg <= 12'd0;
                end
                ST_NDIV: begin
                    if (div_cnt_reg != 4'd0) begin
                        div_cnt_reg <= div_cnt_reg - 4'd1;
                    end
                    if (rem_sh >= {1'b0, span2}) begin
                        rem_reg <= rem_sh - {1'b0, span2};
                        quot_reg <= {quot_reg[10:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quot_reg <= {quot_reg[10:0], 1'b0};
                    end
                    num_reg <= {num_reg[22:0], 1'b0};
                end
                ST_HIST: begin
                    if (s_reg <= lo) s_reg <= 12'd0;
                    else if (s_reg >= hi) s_reg <= 12'd4095;
                    else s_reg <= quot_reg;
                    step_reg <= 3'd0;
                    scan_reg <= 2'd0;
                    oth_reg <= 13'd0;
                end
                ST_WIN: begin
                    if (ph != 8'd0 && ph < cfg.window_length) begin
                        for (int h = 0; h < dphd_pkg::HISTORY_DEPTH - 1; h++)
                            if (4'(h + 1) < hlen) hist_reg[pd][h] <= hist_reg[pd][h + 1];
                        hist_reg[pd][hlast] <= s_reg;
                        if ({1'b0, s_reg} < wmin_reg[pd]) wmin_reg[pd] <= {1'b0, s_reg};
                        else if ({1'b0, s_reg} > wmax_reg[pd]) wmax_reg[pd] <= {1'b0, s_reg};
                    end else begin
                        wmin_reg[pd] <= nmin;
                        wmax_reg[pd] <= nmax;
                        if (4'(step_reg) + 4'd1 < hlen)
                            hist_reg[pd][step_reg] <= hist_reg[pd][step_reg + 3'd1];
                        if (4'(step_reg) + 4'd2 >= hlen)
                            hist_reg[pd][hlast] <= s_reg;
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_OTHER: begin
                    if (scan_reg != pd && scan_lvl > oth_reg) oth_reg <= scan_lvl;
                    scan_reg <= scan_reg + 2'd1;
                end
                ST_ENV: begin
                    p2p_reg <= win_lvl;
                    if (cfg.crosstalk_shift != 3'd0 && ph != 8'd0 && ph < cfg.window_length
                        && ph == (cfg.window_length >> 1) && oth_reg != 13'd0
                        && canc_win <= {1'b0, cfg.on_level})
                        phase_reg[pd] <= 8'd0;
                    if (envc_reg[pd] == 11'd0) begin
                        envth_reg[pd] <= 14'(envmax_reg[pd] - envmin_reg[pd])
                            + {2'b00, cfg.on_level};
                        envmax_reg[pd] <= {1'b0, s_reg};
                        envmin_reg[pd] <= {1'b0, s_reg};
                        envc_reg[pd] <= 11'({3'd0, cfg.window_length}
                            + 11'(cfg.mask_time) * 11'd3 - 11'd1);
                    end else begin
                        if (envmax_reg[pd] < {1'b0, s_reg}) envmax_reg[pd] <= {1'b0, s_reg};
                        if (envmin_reg[pd] > {1'b0, s_reg}) envmin_reg[pd] <= {1'b0, s_reg};
                        envc_reg[pd] <= envc_reg[pd] - 11'd1;
                    end
                    if (retrig_reg[pd] != 10'd0) retrig_reg[pd] <= retrig_reg[pd] - 10'd1;
                end
                ST_PHASE: begin
                    mhit_reg <= 1'b0;
                    mlvl_reg <= 12'd0;
                    if (ph == 8'd0) begin
                        if (((cfg.crosstalk_shift != 3'd0) ? canc_p2p : p2p_reg)
                                > 13'(envth_reg[pd]) && envth_reg[pd][13] == 1'b0
                                && retrig_reg[pd] == 10'd0) begin
                            phase_reg[pd] <= 8'd1;
                            envc_reg[pd] <= 11'(11'(cfg.mask_time) * 11'd3 - 11'd1);
                            envmax_reg[pd] <= wmax_reg[pd];
                            envmin_reg[pd] <= wmin_reg[pd];
                        end
                    end else if (ph < cfg.window_length) begin
                        phase_reg[pd] <= ph + 8'd1;
                        if (ph + 8'd1 == cfg.window_length) begin
                            mhit_reg <= 1'b1;
                            mlvl_reg <= (p2p_reg < {1'b0, cfg.on_level}) ? 12'd0
                                : p2p_reg[11:0];
                            retrig_reg[pd] <= 10'(cfg.mask_time) * 10'd3;
                        end
                    end else if (retrig_reg[pd] == 10'd0) begin
                        phase_reg[pd] <= 8'd0;
                    end
                end
                ST_OUT: begin
                    mvalid_reg <= 1'b1;
                    mpad_reg <= wd_reg.pad;
                    if (!wd_reg.in_range) begin
                        mhit_reg <= 1'b0;
                        mlvl_reg <= 12'd0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/dphd_cfg.sv
module dphd_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [11:0]      cfg_data,
    output dphd_pkg::cfg_t   cfg
);

    dphd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_span <= 11'd2047;
            cfg_reg.on_level <= 12'd100;
            cfg_reg.window_length <= 8'd10;
            cfg_reg.mask_time <= 8'd20;
            cfg_reg.crosstalk_shift <= 3'd0;
            cfg_reg.history_length <= 4'd4;
        end else if (cfg_valid) begin
            case (cfg_index)
                dphd_pkg::CFG_INPUT_SPAN: cfg_reg.input_span <= cfg_data[10:0];
                dphd_pkg::CFG_ON_LEVEL: cfg_reg.on_level <= cfg_data;
                dphd_pkg::CFG_WINDOW_LENGTH: cfg_reg.window_length <= cfg_data[7:0];
                dphd_pkg::CFG_MASK_TIME: cfg_reg.mask_time <= cfg_data[7:0];
                dphd_pkg::CFG_CROSSTALK_SHIFT: cfg_reg.crosstalk_shift <= cfg_data[2:0];
                dphd_pkg::CFG_HISTORY_LENGTH: cfg_reg.history_length <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

endmodule

>>> sim/drum_pad_hit_detector_tb.sv
module drum_pad_hit_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_WORDS = 190;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic        hit;
        logic [11:0] level;
    } strike_t;

    typedef struct {
        logic [1:0]  pad;
        logic [11:0] sample;
        bit          fixed;
        logic        hit;
        logic [11:0] level;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_pad_index;
    logic [11:0] s_adc_sample;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_pad_number;
    logic        m_hit;
    logic [11:0] m_strike_level;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    drum_pad_hit_detector uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pad_index(s_pad_index), .s_adc_sample(s_adc_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pad_number(m_pad_number), .m_hit(m_hit), .m_strike_level(m_strike_level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the configuration and per-pad state.
    int span, on_lvl, win_len, mask_len, xt_shift, hist_len;
    int phase_cnt[dphd_pkg::PADS];
    int retrig_cnt[dphd_pkg::PADS];
    int hist[dphd_pkg::PADS][dphd_pkg::HISTORY_DEPTH];
    int win_min[dphd_pkg::PADS], win_max[dphd_pkg::PADS];
    int in_dly[dphd_pkg::PADS][2];
    int filt_dly[dphd_pkg::PADS][2];
    int env_cnt[dphd_pkg::PADS], env_min[dphd_pkg::PADS];
    int env_max[dphd_pkg::PADS], env_thr[dphd_pkg::PADS];

    strike_t    pending_strikes[$];
    int         errors;
    int         cycles;
    idle_mode_t idle_mode;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int wrap16(int v);
        int u;
        u = v & 16'hFFFF;
        return (u & 16'h8000) ? u - 65536 : u;
    endfunction

    function automatic int other_pads_level(int pad);
        int best, lvl;
        best = 0;
        for (int i = 0; i < dphd_pkg::PADS; i++) begin
            if (i != pad) begin
                lvl = win_max[i] - win_min[i];
                lvl = lvl >> ((i == (pad ^ 1)) ? 1 : 2);
                if (lvl > best) best = lvl;
            end
        end
        return best;
    endfunction

    function automatic int cancel_xtalk(int pad, int level);
        int x;
        x = other_pads_level(pad);
        if (x != 0) begin
            x = x >> xt_shift;
            level = (level > x) ? level - x : 0;
        end
        return level;
    endfunction

    function automatic void reset_model();
        span = 2047; on_lvl = 100; win_len = 10; mask_len = 20; xt_shift = 0; hist_len = 4;
        for (int p = 0; p < dphd_pkg::PADS; p++) begin
            phase_cnt[p] = 10; retrig_cnt[p] = 0;
            win_min[p] = 0; win_max[p] = 0;
            env_cnt[p] = 0; env_min[p] = 0; env_max[p] = 0; env_thr[p] = 0;
            for (int i = 0; i < dphd_pkg::HISTORY_DEPTH; i++) hist[p][i] = 0;
            for (int i = 0; i < 2; i++) begin
                in_dly[p][i] = 2048; filt_dly[p][i] = 0;
            end
        end
    endfunction

    function automatic strike_t predict_strike(int pad, int raw);
        strike_t r;
        int f1, f2, s, lo, hi, hl, v, p2p, lvl;
        r.pad = pad[1:0];
        r.hit = 1'b0;
        r.level = '0;

        f1 = (raw - (in_dly[pad][0] + in_dly[pad][1]) / 2) * 3 / 16;
        f2 = wrap16(f1 + (filt_dly[pad][0] * 7 / 4 - filt_dly[pad][1] * 8 / 10));
        in_dly[pad][1] = in_dly[pad][0];
        in_dly[pad][0] = raw;
        filt_dly[pad][1] = filt_dly[pad][0];
        filt_dly[pad][0] = f2;
        f2 = wrap16(f2 + 2048);
        s = (f2 < 0) ? 0 : (f2 > 4095) ? 4095 : f2;

        lo = 2048 - span;
        hi = 2048 + span;
        if (s <= lo) s = 0;
        else if (s >= hi) s = 4095;
        else s = (s - lo) * 4095 / (hi - lo);

        hl = hist_len;
        if (hl == 0) hl = 1;
        if (hl > dphd_pkg::HISTORY_DEPTH) hl = dphd_pkg::HISTORY_DEPTH;

        if (phase_cnt[pad] != 0 && phase_cnt[pad] < win_len) begin
            for (int i = 0; i + 1 < hl; i++) hist[pad][i] = hist[pad][i + 1];
            hist[pad][hl - 1] = s;
            if (s < win_min[pad]) win_min[pad] = s;
            else if (s > win_max[pad]) win_max[pad] = s;
            // Halfway through the window a strike that is mostly crosstalk is dropped.
            if (xt_shift != 0 && phase_cnt[pad] == win_len / 2) begin
                lvl = win_max[pad] - win_min[pad];
                if (other_pads_level(pad) != 0) begin
                    lvl = cancel_xtalk(pad, lvl);
                    if (lvl <= on_lvl) phase_cnt[pad] = 0;
                end
            end
        end else begin
            win_min[pad] = s;
            win_max[pad] = s;
            for (int i = 0; i + 1 < hl; i++) begin
                v = hist[pad][i + 1];
                hist[pad][i] = v;
                if (v < win_min[pad]) win_min[pad] = v;
                else if (v > win_max[pad]) win_max[pad] = v;
            end
            hist[pad][hl - 1] = s;
        end

        if (env_cnt[pad] == 0) begin
            env_thr[pad] = env_max[pad] - env_min[pad] + on_lvl;
            env_max[pad] = s;
            env_min[pad] = s;
            env_cnt[pad] = (win_len + mask_len * 3 - 1) & 11'h7FF;
        end else begin
            if (env_max[pad] < s) env_max[pad] = s;
            if (env_min[pad] > s) env_min[pad] = s;
            env_cnt[pad]--;
        end

        p2p = win_max[pad] - win_min[pad];
        if (retrig_cnt[pad] != 0) retrig_cnt[pad]--;

        if (phase_cnt[pad] == 0) begin
            lvl = p2p;
            if (xt_shift != 0) lvl = cancel_xtalk(pad, lvl);
            if (lvl > env_thr[pad] && retrig_cnt[pad] == 0) begin
                phase_cnt[pad] = 1;
                env_cnt[pad] = (mask_len * 3 - 1) & 11'h7FF;
                env_max[pad] = win_max[pad];
                env_min[pad] = win_min[pad];
            end
        end else if (phase_cnt[pad] < win_len) begin
            phase_cnt[pad]++;
            if (phase_cnt[pad] == win_len) begin
                r.hit = 1'b1;
                r.level = (p2p < on_lvl) ? 12'd0 : p2p[11:0];
                retrig_cnt[pad] = mask_len * 3;
            end
        end else begin
            if (retrig_cnt[pad] == 0) phase_cnt[pad] = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    endtask

    // Sends one sample word; entered and left at a rising edge.
    task automatic send_sample(int pad, int sample, bit fixed = 0,
                               logic hit = 0, logic [11:0] level = 0);
        strike_t r;
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SENDER) ? 74 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid      <= 1'b1;
        s_pad_index  <= pad[1:0];
        s_adc_sample <= sample[11:0];
        do @(posedge aclk); while (!s_ready);
        r = predict_strike(pad, sample);
        if (fixed) begin
            r.hit = hit;
            r.level = level;
        end
        pending_strikes.push_back(r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_strikes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[11:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dphd_pkg::CFG_INPUT_SPAN:      span     = value & 12'h7FF;
            dphd_pkg::CFG_ON_LEVEL:        on_lvl   = value & 12'hFFF;
            dphd_pkg::CFG_WINDOW_LENGTH:   win_len  = value & 12'hFF;
            dphd_pkg::CFG_MASK_TIME:       mask_len = value & 12'hFF;
            dphd_pkg::CFG_CROSSTALK_SHIFT: xt_shift = value & 12'h7;
            dphd_pkg::CFG_HISTORY_LENGTH:  hist_len = value & 12'hF;
            default: ;
        endcase
    endtask

    task automatic write_all(int sp, int onl, int wl, int mt, int xs, int hl);
        write_reg(dphd_pkg::CFG_INPUT_SPAN, sp);
        write_reg(dphd_pkg::CFG_ON_LEVEL, onl);
        write_reg(dphd_pkg::CFG_WINDOW_LENGTH, wl);
        write_reg(dphd_pkg::CFG_MASK_TIME, mt);
        write_reg(dphd_pkg::CFG_CROSSTALK_SHIFT, xs);
        write_reg(dphd_pkg::CFG_HISTORY_LENGTH, hl);
        cfg_valid <= 1'b0;
    endtask

    // Mostly strike bursts: a large swing that decays; the rest is noise.
    task automatic random_traffic(int words);
        int sent, pad, amp, len, smp;
        sent = 0;
        while (sent < words) begin
            if ($urandom_range(99) < 75) begin
                pad = $urandom_range(dphd_pkg::PADS - 1);
                amp = $urandom_range(4095, 200);
                len = $urandom_range(30, 4);
                for (int k = 0; k < len && sent < words; k++) begin
                    smp = 2048 + (((k & 1) != 0) ? amp / 2 : -amp / 2)
                          + $urandom_range(64) - 32;
                    smp = (smp < 0) ? 0 : (smp > 4095) ? 4095 : smp;
                    // Now and then a neighbor gets a small sample near mid-scale in place of the strike sample.
                    if ($urandom_range(3) == 0)
                        send_sample(pad ^ $urandom_range(3, 1), 2048 + $urandom_range(200) - 100);
                    else
                        send_sample(pad, smp);
                    sent++;
                    amp = amp * 7 / 8;
                end
            end else begin
                send_sample($urandom_range(dphd_pkg::PADS - 1), $urandom_range(4095));
                sent++;
            end
        end
    endtask

    stim_row_t directed[] = '{
        '{0, 12'd2048, 1, 1'b0, 12'd0}, '{1, 12'd0,    1, 1'b0, 12'd0},
        '{2, 12'd4095, 1, 1'b0, 12'd0}, '{3, 12'd2048, 1, 1'b0, 12'd0},
        '{0, 12'd4095, 0, 0, 0}, '{0, 12'd0,    0, 0, 0}, '{0, 12'd4095, 0, 0, 0},
        '{0, 12'd0,    0, 0, 0}, '{1, 12'd2300, 0, 0, 0}, '{0, 12'd4095, 0, 0, 0},
        '{0, 12'd0,    0, 0, 0}, '{0, 12'd3500, 0, 0, 0}, '{0, 12'd600,  0, 0, 0},
        '{0, 12'd2048, 0, 0, 0}, '{0, 12'd2048, 0, 0, 0}, '{0, 12'd2048, 0, 0, 0},
        '{0, 12'd2048, 0, 0, 0}, '{3, 12'd4095, 0, 0, 0}, '{3, 12'd0,    0, 0, 0},
        '{2, 12'd0,    0, 0, 0}, '{2, 12'd4095, 0, 0, 0}, '{2, 12'd2048, 0, 0, 0},
        '{1, 12'd4095, 0, 0, 0}, '{1, 12'd1,    0, 0, 0}
    };

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_strikes.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                strike_t want;
                want = pending_strikes.pop_front();
                if (m_pad_number !== want.pad) report_mismatch("pad_number", m_pad_number, want.pad);
                if (m_hit !== want.hit) report_mismatch("hit", m_hit, want.hit);
                if (m_strike_level !== want.level)
                    report_mismatch("strike_level", m_strike_level, want.level);
            end
        end
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= ($urandom_range(99) >= 74);
            IDLE_BOTH:     m_ready <= ($urandom_range(99) >= 18);
            default:       m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** drum_pad_hit_detector: FAILED **");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        idle_mode = IDLE_NONE;
        aresetn = 1'b0;
        s_valid = 1'b0; s_pad_index = '0; s_adc_sample = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_sample(directed[i].pad, directed[i].sample, directed[i].fixed,
                        directed[i].hit, directed[i].level);
        random_traffic(PHASE_WORDS);
        drain();

        // Lower extremes, with the largest crosstalk shift.
        idle_mode = IDLE_SENDER;
        write_all(1, 0, 2, 0, 7, 8);
        random_traffic(PHASE_WORDS);
        drain();

        idle_mode = IDLE_RECEIVER;
        write_all(2047, 4095, 255, 255, 0, 1);
        random_traffic(PHASE_WORDS / 2);
        drain();
        write_all(2047, 50, 12, 3, 1, 15);
        random_traffic(PHASE_WORDS / 2);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_mode = (ph == 0) ? IDLE_BOTH : (ph == 1) ? IDLE_NONE : IDLE_SENDER;
            write_all(($urandom_range(7) == 0) ? 0 : $urandom_range(2047),
                      $urandom_range(600), $urandom_range(40), $urandom_range(20),
                      $urandom_range(7), $urandom_range(15));
            random_traffic(PHASE_WORDS / 2);
            // Let the pipeline run dry once in the middle of the traffic.
            drain();
            random_traffic(PHASE_WORDS / 2);
            drain();
        end

        if (errors == 0) begin
            $display("** drum_pad_hit_detector: PASSED **");
        end else begin
            $display("** drum_pad_hit_detector: FAILED **");
        end
        $finish;
    end

endmodule
